[rtl/pasbp_pkg.sv]
// shared types and constants for the parsimony allele set backward pass
package pasbp_pkg;

	// field widths of one input item and one result item
	localparam int unsigned INDEX_W  = 12;
	localparam int unsigned COUNT_W  = 9;
	localparam int unsigned ALLELE_W = 4;

	// per-allele child tally, never more than the largest child count
	localparam int unsigned TALLY_W = COUNT_W;

	// packed stream widths, whole bytes
	localparam int unsigned IN_BITS  = 2 * INDEX_W + COUNT_W + 1 + ALLELE_W;
	localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS = INDEX_W + 2 * ALLELE_W + 1;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_REFERENCE_ALLELE = 3'd0;
	localparam logic [ALLELE_W-1:0]   REFERENCE_RESET      = 4'h1;

	// input item, last declared field in the lowest bits
	typedef struct packed {
		logic [ALLELE_W-1:0] leaf_allele;
		logic                leaf_is_mutated;
		logic [INDEX_W-1:0]  first_child_index;
		logic [COUNT_W-1:0]  child_count;
		logic [INDEX_W-1:0]  node_index;
	} node_item_t;

	// result item, last declared field in the lowest bits
	typedef struct packed {
		logic                error_flag;
		logic [ALLELE_W-1:0] boundary_alleles;
		logic [ALLELE_W-1:0] major_alleles;
		logic [INDEX_W-1:0]  result_index;
	} result_item_t;

	typedef logic [TALLY_W-1:0] tally_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_TOP   = 6'b010000,
		ST_WRITE = 6'b100000
	} seq_state_t;

endpackage

[rtl/parsimony_allele_set_backward_pass_top.sv]
// backward parsimony pass: child tally sequencer over a per-node allele store
//
// channel  dir  signals                          contents
// s_*      in   tvalid tready tdata[39:0]        one tree node to resolve
// m_*      out  tvalid tready tdata[23:0]        resolved byte of that node
// apb      in   psel penable pwrite paddr pwdata reference_allele at 0x0
//
// a leaf or a rejected node goes from check straight to write; a node with
// children passes fetch, drain and top first. The store has one read port, so
// one child byte is fetched per cycle. Reset clears the sequencer, the output
// valid and reference_allele (to A); the store itself holds nothing defined
// until a node is written. s_tready is high only while the sequencer is idle; a
// result waits in the output register, and a next result stalls in the write state until taken.
module parsimony_allele_set_backward_pass_top #(
	parameter int unsigned NODE_COUNT   = 4096,
	parameter int unsigned MAX_CHILDREN = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave side
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// node_index[11:0] child_count[20:12] first_child_index[32:21]
	// leaf_is_mutated[33] leaf_allele[37:34] zero[39:38]
	input  logic [pasbp_pkg::IN_W-1:0]           s_tdata,
	// master side
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// result_index[11:0] major_alleles[15:12] boundary_alleles[19:16]
	// error_flag[20] zero[23:21]
	output logic [pasbp_pkg::OUT_W-1:0]          m_tdata,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pasbp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pasbp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pasbp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready
);

	localparam int unsigned ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	pasbp_pkg::seq_state_t state_q;
	pasbp_pkg::node_item_t item_q;
	pasbp_pkg::node_item_t in_item;
	pasbp_pkg::result_item_t out_q;

	logic [pasbp_pkg::ALLELE_W-1:0] ref_q;
	logic                           out_valid_q;
	logic                           bad_q;
	logic                           leaf_q;
	logic [ADDR_W-1:0]              rd_addr_q;
	logic [pasbp_pkg::COUNT_W-1:0]  remain_q;
	logic                           rd_vld_s1;
	logic [7:0]                     rd_data_s1;
	pasbp_pkg::tally_t              tally_q [pasbp_pkg::ALLELE_W];
	pasbp_pkg::tally_t              top_q;

	logic [7:0] store [NODE_COUNT];

	logic                           cfg_wr;
	logic                           rd_en;
	logic                           wr_go;
	logic                           range_bad;
	pasbp_pkg::tally_t              max01;
	pasbp_pkg::tally_t              max23;
	pasbp_pkg::tally_t              top_next;
	logic [pasbp_pkg::ALLELE_W-1:0] t_nz;
	logic [pasbp_pkg::ALLELE_W-1:0] t_two;
	logic [pasbp_pkg::ALLELE_W-1:0] t_top;
	logic [pasbp_pkg::ALLELE_W-1:0] t_edge;
	logic [pasbp_pkg::ALLELE_W-1:0] major;
	logic [pasbp_pkg::ALLELE_W-1:0] bound;

	assign in_item  = pasbp_pkg::node_item_t'(s_tdata[pasbp_pkg::IN_BITS-1:0]);
	assign s_tready = (state_q == pasbp_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(pasbp_pkg::OUT_W - pasbp_pkg::OUT_BITS){1'b0}}, out_q};

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == pasbp_pkg::REG_REFERENCE_ALLELE);
	assign prdata = (paddr == pasbp_pkg::REG_REFERENCE_ALLELE) ?
		{{(pasbp_pkg::APB_DATA_W - pasbp_pkg::ALLELE_W){1'b0}}, ref_q} :
		'0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= pasbp_pkg::REFERENCE_RESET;
		end else if (cfg_wr) begin
			ref_q <= pwdata[pasbp_pkg::ALLELE_W-1:0];
		end
	end

	// request range check on the captured item
	assign range_bad =
		(32'(item_q.node_index) >= 32'(NODE_COUNT)) ||
		(32'(item_q.child_count) > 32'(MAX_CHILDREN)) ||
		((item_q.child_count != '0) &&
		 (32'(item_q.first_child_index) + 32'(item_q.child_count) > 32'(NODE_COUNT)));

	assign rd_en = (state_q == pasbp_pkg::ST_FETCH);
	assign wr_go = (state_q == pasbp_pkg::ST_WRITE) && (!out_valid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pasbp_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				pasbp_pkg::ST_IDLE: begin
					if (s_tvalid) state_q <= pasbp_pkg::ST_CHECK;
				end
				pasbp_pkg::ST_CHECK: begin
					if (range_bad || item_q.child_count == '0) state_q <= pasbp_pkg::ST_WRITE;
					else state_q <= pasbp_pkg::ST_FETCH;
				end
				pasbp_pkg::ST_FETCH: begin
					if (remain_q == pasbp_pkg::COUNT_W'(1)) state_q <= pasbp_pkg::ST_DRAIN;
				end
				pasbp_pkg::ST_DRAIN: begin
					state_q <= pasbp_pkg::ST_TOP;
				end
				pasbp_pkg::ST_TOP: begin
					state_q <= pasbp_pkg::ST_WRITE;
				end
				pasbp_pkg::ST_WRITE: begin
					if (wr_go) state_q <= pasbp_pkg::ST_IDLE;
				end
				default: begin
					state_q <= pasbp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// item capture and node kind
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_q <= in_item;
		if (state_q == pasbp_pkg::ST_CHECK) begin
			bad_q  <= range_bad;
			leaf_q <= (item_q.child_count == '0);
		end
	end

	// child address walk
	always_ff @(posedge clk) begin
		if (state_q == pasbp_pkg::ST_CHECK) begin
			rd_addr_q <= ADDR_W'(item_q.first_child_index);
			remain_q  <= item_q.child_count;
		end else if (rd_en) begin
			rd_addr_q <= rd_addr_q + ADDR_W'(1);
			remain_q  <= remain_q - pasbp_pkg::COUNT_W'(1);
		end
	end

	// allele store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_go && !bad_q) store[ADDR_W'(item_q.node_index)] <= {bound, major};
		if (rd_en) rd_data_s1 <= store[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	// per-allele tally of the children's major bits
	always_ff @(posedge clk) begin
		for (int k = 0; k < pasbp_pkg::ALLELE_W; k++) begin
			if (state_q == pasbp_pkg::ST_CHECK) tally_q[k] <= '0;
			else if (rd_vld_s1) tally_q[k] <= tally_q[k] + pasbp_pkg::TALLY_W'(rd_data_s1[k]);
		end
	end

	// maximum tally
	assign max01    = (tally_q[0] > tally_q[1]) ? tally_q[0] : tally_q[1];
	assign max23    = (tally_q[2] > tally_q[3]) ? tally_q[2] : tally_q[3];
	assign top_next = (max01 > max23) ? max01 : max23;

	always_ff @(posedge clk) begin
		if (state_q == pasbp_pkg::ST_TOP) top_q <= top_next;
	end

	// allele set classes from the tallies
	always_comb begin
		for (int k = 0; k < pasbp_pkg::ALLELE_W; k++) begin
			t_nz[k]   = (tally_q[k] != '0);
			t_two[k]  = (tally_q[k] == pasbp_pkg::TALLY_W'(2));
			t_top[k]  = (tally_q[k] == top_q);
			t_edge[k] = ({1'b0, tally_q[k]} + (pasbp_pkg::TALLY_W + 1)'(1) == {1'b0, top_q});
		end
	end

	// resolved byte by node kind
	always_comb begin
		major = '0;
		bound = '0;
		priority if (bad_q) begin
			major = '0;
			bound = '0;
		end else if (leaf_q) begin
			major = item_q.leaf_is_mutated ? item_q.leaf_allele : ref_q;
		end else if (item_q.child_count == pasbp_pkg::COUNT_W'(1)) begin
			major = t_nz;
		end else if (item_q.child_count == pasbp_pkg::COUNT_W'(2)) begin
			if (t_two != '0) begin
				major = t_two;
				bound = t_nz & ~t_two;
			end else begin
				major = t_nz;
				bound = ~t_nz;
			end
		end else begin
			major = t_top;
			bound = t_edge;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			out_q.result_index     <= item_q.node_index;
			out_q.major_alleles    <= major;
			out_q.boundary_alleles <= bound;
			out_q.error_flag       <= bad_q || (major == '0);
		end
	end

endmodule
